/* rtl/viewport_rect_scale_clip_flip_macros.svh */
// ----------------------------------------------------------------------------
// viewport rectangle scaler assertion macros
// clocked property wrappers used by the checker file
// ----------------------------------------------------------------------------
`ifndef VIEWPORT_RECT_SCALE_CLIP_FLIP_MACROS_SVH
`define VIEWPORT_RECT_SCALE_CLIP_FLIP_MACROS_SVH

// property checked outside reset
`define VRSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define VRSC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/vrsc_pkg.sv */
// ----------------------------------------------------------------------------
// vrsc_pkg
// widths, register codes and divider cell record for the rectangle scaler
// ----------------------------------------------------------------------------
`default_nettype none
package vrsc_pkg;
	localparam int CB     = 14;          // coordinate bits
	localparam int QW     = CB + 1;      // quotient and divisor width
	localparam int PW     = 2 * CB;      // product width
	localparam int DW     = 2 * CB + 2;  // dividend width
	localparam int NCELL  = QW;          // one quotient bit per cell
	localparam int NLANE  = 4;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam int LANE_X = 0;
	localparam int LANE_T = 1;
	localparam int LANE_W = 2;
	localparam int LANE_H = 3;

	typedef enum logic [1:0] {
		REG_TW = 2'd0,
		REG_TH = 2'd1,
		REG_SW = 2'd2,
		REG_SH = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic          ovf;
		logic [QW-1:0] rem;
		logic [QW-1:0] low;
		logic [QW-1:0] quo;
	} div_t;
endpackage
`default_nettype wire

/* rtl/vrsc_if.sv */
// ----------------------------------------------------------------------------
// vrsc channel interfaces
// rectangle input channel and result channel with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none
interface vrsc_rect_if;
	logic                     valid;
	logic                     ready;
	logic signed [vrsc_pkg::CB:0]   rect_x;
	logic signed [vrsc_pkg::CB:0]   rect_top;
	logic        [vrsc_pkg::CB-1:0] rect_width;
	logic        [vrsc_pkg::CB-1:0] rect_height;
	modport source (output valid, rect_x, rect_top, rect_width, rect_height, input ready);
	modport sink (input valid, rect_x, rect_top, rect_width, rect_height, output ready);
endinterface

interface vrsc_res_if;
	logic                      valid;
	logic                      ready;
	logic [vrsc_pkg::CB-1:0]   out_x;
	logic [vrsc_pkg::CB-1:0]   out_bottom;
	logic [vrsc_pkg::CB-1:0]   out_width;
	logic [vrsc_pkg::CB-1:0]   out_height;
	modport source (output valid, out_x, out_bottom, out_width, out_height, input ready);
	modport sink (input valid, out_x, out_bottom, out_width, out_height, output ready);
endinterface
`default_nettype wire

/* rtl/viewport_rect_scale_clip_flip.sv */
// ----------------------------------------------------------------------------
// viewport_rect_scale_clip_flip
// maps a source-window rectangle to target pixels, clipped and y-flipped
// ----------------------------------------------------------------------------
// usage:
//   program target_width/height and source_width/height over the apb port
//   (byte addresses 0, 4, 8, 12) while the block holds no transaction
//   rect channel: one transaction per rectangle, rect_x/rect_top signed
//   res channel: exactly one result transaction per rectangle, in order
// pipeline: an accepted rectangle passes the product stage, the dividend
//   stage, one divider cell per quotient bit, and the output register
// throughput: one rectangle per cycle while no result is stalled; each lane is a
//   chain of 15 division cells, each handing its partial remainder to the next
// stall: when a result waits on res, the whole pipeline holds and rect.ready
//   drops; the pipeline moves again the cycle the result is taken
// reset: arst_n clears the size registers and pipeline valid bits, no clearing pass;
//   all size registers read zero, so results are the full (empty) target
// ----------------------------------------------------------------------------
`default_nettype none
module viewport_rect_scale_clip_flip (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [vrsc_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [vrsc_pkg::DATA_W-1:0]     pwdata,
	output logic      [vrsc_pkg::DATA_W-1:0]     prdata,
	output logic                                 pready,
	vrsc_rect_if.sink                            rect,
	vrsc_res_if.source                           res
);
	localparam int CB    = vrsc_pkg::CB;
	localparam int QW    = vrsc_pkg::QW;
	localparam int PW    = vrsc_pkg::PW;
	localparam int DW    = vrsc_pkg::DW;
	localparam int NCELL = vrsc_pkg::NCELL;
	localparam int NLANE = vrsc_pkg::NLANE;

	// configuration registers
	logic [CB-1:0] tw_q, th_q, sw_q, sh_q;
	vrsc_pkg::reg_idx_t widx;

	assign pready = 1'b1;
	assign widx   = vrsc_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q <= '0;
			th_q <= '0;
			sw_q <= '0;
			sh_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (widx)
				vrsc_pkg::REG_TW: tw_q <= pwdata[CB-1:0];
				vrsc_pkg::REG_TH: th_q <= pwdata[CB-1:0];
				vrsc_pkg::REG_SW: sw_q <= pwdata[CB-1:0];
				vrsc_pkg::REG_SH: sh_q <= pwdata[CB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			vrsc_pkg::REG_TW: prdata = {{(vrsc_pkg::DATA_W-CB){1'b0}}, tw_q};
			vrsc_pkg::REG_TH: prdata = {{(vrsc_pkg::DATA_W-CB){1'b0}}, th_q};
			vrsc_pkg::REG_SW: prdata = {{(vrsc_pkg::DATA_W-CB){1'b0}}, sw_q};
			vrsc_pkg::REG_SH: prdata = {{(vrsc_pkg::DATA_W-CB){1'b0}}, sh_q};
			default:          prdata = '0;
		endcase
	end

	// global advance: everything moves unless a result sits untaken
	logic en;
	logic out_valid_q;
	assign en         = !out_valid_q || res.ready;
	assign rect.ready = en;

	// per-lane scale factor and divisor (x, top, width, height)
	logic [CB-1:0] num   [NLANE];
	logic [CB-1:0] den   [NLANE];
	logic [CB-1:0] mag   [NLANE];
	assign num[vrsc_pkg::LANE_X] = tw_q;
	assign num[vrsc_pkg::LANE_W] = tw_q;
	assign num[vrsc_pkg::LANE_T] = th_q;
	assign num[vrsc_pkg::LANE_H] = th_q;
	assign den[vrsc_pkg::LANE_X] = sw_q;
	assign den[vrsc_pkg::LANE_W] = sw_q;
	assign den[vrsc_pkg::LANE_T] = sh_q;
	assign den[vrsc_pkg::LANE_H] = sh_q;
	// negative origin clamps to zero, which scales to zero
	assign mag[vrsc_pkg::LANE_X] = rect.rect_x[CB]   ? '0 : rect.rect_x[CB-1:0];
	assign mag[vrsc_pkg::LANE_T] = rect.rect_top[CB] ? '0 : rect.rect_top[CB-1:0];
	assign mag[vrsc_pkg::LANE_W] = rect.rect_width;
	assign mag[vrsc_pkg::LANE_H] = rect.rect_height;

	// valid bits for product stage, dividend stage and each cell
	logic             v_s1, v_s2;
	logic [NCELL-1:0] vc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			vc_q        <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= rect.valid;
			v_s2        <= v_s1;
			vc_q        <= {vc_q[NCELL-2:0], v_s2};
			out_valid_q <= vc_q[NCELL-1];
		end
	end

	logic [PW-1:0]  prod_s1 [NLANE];
	vrsc_pkg::div_t init_s2 [NLANE];
	vrsc_pkg::div_t chain   [NLANE][NCELL+1];

	for (genvar l = 0; l < NLANE; l++) begin : g_lane
		logic [DW-1:0] dvd;
		logic [QW-1:0] dsr;
		vrsc_pkg::div_t init_nxt;

		// round half away: (2*mag*num + den) / (2*den)
		assign dsr = {den[l], 1'b0};
		always_comb begin
			dvd = {1'b0, prod_s1[l], 1'b0} + DW'(den[l]);
			init_nxt.rem = dvd[DW-1:QW];
			init_nxt.low = dvd[QW-1:0];
			init_nxt.quo = '0;
			// quotient too big for the cells: saturate, always past target
			init_nxt.ovf = dvd[DW-1:QW] >= dsr;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				prod_s1[l] <= PW'(mag[l]) * PW'(num[l]);
				init_s2[l] <= init_nxt;
			end
		end

		assign chain[l][0] = init_s2[l];

		for (genvar c = 0; c < NCELL; c++) begin : g_cell
			vrsc_div_cell u_cell (
				.clk     (clk),
				.en      (en),
				.divisor (dsr),
				.d_in    (chain[l][c]),
				.d_out   (chain[l][c+1])
			);
		end
	end

	// clip and flip, then the output register
	logic [CB-1:0] cx, cb, cw, ch;

	vrsc_clip u_clip (
		.tw         (tw_q),
		.th         (th_q),
		.sw         (sw_q),
		.sh         (sh_q),
		.qx         (chain[vrsc_pkg::LANE_X][NCELL]),
		.qt         (chain[vrsc_pkg::LANE_T][NCELL]),
		.qw         (chain[vrsc_pkg::LANE_W][NCELL]),
		.qh         (chain[vrsc_pkg::LANE_H][NCELL]),
		.out_x      (cx),
		.out_bottom (cb),
		.out_width  (cw),
		.out_height (ch)
	);

	logic [CB-1:0] ox_q, ob_q, ow_q, oh_q;

	always_ff @(posedge clk) begin
		if (en) begin
			ox_q <= cx;
			ob_q <= cb;
			ow_q <= cw;
			oh_q <= ch;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.out_x      = ox_q;
	assign res.out_bottom = ob_q;
	assign res.out_width  = ow_q;
	assign res.out_height = oh_q;
endmodule
`default_nettype wire

/* rtl/vrsc_div_cell.sv */
// ----------------------------------------------------------------------------
// vrsc_div_cell
// one restoring division step, registered, producing one quotient bit
// ----------------------------------------------------------------------------
`default_nettype none
module vrsc_div_cell (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic [vrsc_pkg::QW-1:0] divisor,
	input  wire vrsc_pkg::div_t          d_in,
	output vrsc_pkg::div_t               d_out
);
	logic [vrsc_pkg::QW:0]   trial;
	logic [vrsc_pkg::QW:0]   diff;
	logic                    ge;
	vrsc_pkg::div_t          d_nxt;
	vrsc_pkg::div_t          d_q;

	always_comb begin
		trial = {d_in.rem, d_in.low[vrsc_pkg::QW-1]};
		diff  = trial - {1'b0, divisor};
		ge    = trial >= {1'b0, divisor};
		d_nxt.ovf = d_in.ovf;
		d_nxt.rem = ge ? diff[vrsc_pkg::QW-1:0] : trial[vrsc_pkg::QW-1:0];
		d_nxt.low = {d_in.low[vrsc_pkg::QW-2:0], 1'b0};
		d_nxt.quo = {d_in.quo[vrsc_pkg::QW-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= d_nxt;
		end
	end

	assign d_out = d_q;
endmodule
`default_nettype wire

/* rtl/vrsc_clip.sv */
// ----------------------------------------------------------------------------
// vrsc_clip
// clamp, clip to target edge, bottom-origin flip and full-target fallback
// ----------------------------------------------------------------------------
`default_nettype none
module vrsc_clip (
	input  wire logic [vrsc_pkg::CB-1:0] tw,
	input  wire logic [vrsc_pkg::CB-1:0] th,
	input  wire logic [vrsc_pkg::CB-1:0] sw,
	input  wire logic [vrsc_pkg::CB-1:0] sh,
	input  wire vrsc_pkg::div_t          qx,
	input  wire vrsc_pkg::div_t          qt,
	input  wire vrsc_pkg::div_t          qw,
	input  wire vrsc_pkg::div_t          qh,
	output logic [vrsc_pkg::CB-1:0]      out_x,
	output logic [vrsc_pkg::CB-1:0]      out_bottom,
	output logic [vrsc_pkg::CB-1:0]      out_width,
	output logic [vrsc_pkg::CB-1:0]      out_height
);
	localparam int CB = vrsc_pkg::CB;
	localparam int QW = vrsc_pkg::QW;

	logic          full;
	logic [QW:0]   x_end;
	logic [QW:0]   t_end;
	logic [CB-1:0] wc;
	logic [CB-1:0] hc;

	always_comb begin
		full = (tw == '0) || (th == '0) || (sw == '0) || (sh == '0) ||
			qx.ovf || qt.ovf ||
			(qx.quo >= {1'b0, tw}) || (qt.quo >= {1'b0, th});
		x_end = {1'b0, qx.quo} + {1'b0, qw.quo};
		t_end = {1'b0, qt.quo} + {1'b0, qh.quo};
		// size past the edge is cut to end at the edge
		if (qw.ovf || (x_end > {2'b00, tw})) begin
			wc = tw - qx.quo[CB-1:0];
		end else begin
			wc = qw.quo[CB-1:0];
		end
		if (qh.ovf || (t_end > {2'b00, th})) begin
			hc = th - qt.quo[CB-1:0];
		end else begin
			hc = qh.quo[CB-1:0];
		end
		if (full || (wc == '0) || (hc == '0)) begin
			out_x      = '0;
			out_bottom = '0;
			out_width  = tw;
			out_height = th;
		end else begin
			out_x      = qx.quo[CB-1:0];
			out_bottom = th - (qt.quo[CB-1:0] + hc);
			out_width  = wc;
			out_height = hc;
		end
	end
endmodule
`default_nettype wire

/* rtl/vrsc_checker.sv */
// ----------------------------------------------------------------------------
// vrsc_checker
// port-level checks on the rectangle scaler, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "viewport_rect_scale_clip_flip_macros.svh"
module vrsc_checker (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    rect_ready,
	input wire logic                    res_valid,
	input wire logic                    res_ready,
	input wire logic [vrsc_pkg::CB-1:0] res_out_width
);
	`VRSC_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid, "result dropped while stalled")
	`VRSC_ASSERT(a_res_stable, res_valid && !res_ready |=> $stable(res_out_width), "result changed while stalled")
	`VRSC_ASSERT(a_stall_back, res_valid && !res_ready |-> !rect_ready, "input taken while output stalled")
	`VRSC_ASSERT_ALWAYS(a_ready_why, !rect_ready |-> res_valid, "input blocked without a waiting result")
endmodule

bind viewport_rect_scale_clip_flip vrsc_checker u_vrsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rect_ready    (rect.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_out_width (res.out_width)
);
`default_nettype wire

/* tb/tb_viewport_rect_scale_clip_flip.sv */
// ----------------------------------------------------------------------------
// tb_viewport_rect_scale_clip_flip
// drives rectangles under several viewport settings through the scaler and
// checks each result against a cycle-free predictor of the scale, clip and
// flip, with random idling on both channels in part of the run
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

// expected results held in order of acceptance
class rect_scoreboard;
	typedef struct packed {
		logic [vrsc_pkg::CB-1:0] x;
		logic [vrsc_pkg::CB-1:0] bottom;
		logic [vrsc_pkg::CB-1:0] w;
		logic [vrsc_pkg::CB-1:0] h;
	} rect_res_t;

	rect_res_t pending[$];
	int errors;
	int checked;
	logic [vrsc_pkg::CB-1:0] tw, th, sw, sh;

	function void set_reg(vrsc_pkg::reg_idx_t idx, logic [vrsc_pkg::CB-1:0] v);
		case (idx)
			vrsc_pkg::REG_TW: tw = v;
			vrsc_pkg::REG_TH: th = v;
			vrsc_pkg::REG_SW: sw = v;
			default: sh = v;
		endcase
	endfunction

	// half away from zero on a non-negative magnitude
	function longint unsigned scaled(longint unsigned mag, longint unsigned num,
		longint unsigned den);
		return (2 * mag * num + den) / (2 * den);
	endfunction

	function void note_rect(logic signed [vrsc_pkg::CB:0] rx, logic signed [vrsc_pkg::CB:0] rt,
		logic [vrsc_pkg::CB-1:0] rw, logic [vrsc_pkg::CB-1:0] rh);
		rect_res_t r;
		longint unsigned x, t, w, h, b;
		r = '{x: '0, bottom: '0, w: tw, h: th};
		if (tw != 0 && th != 0 && sw != 0 && sh != 0) begin
			x = rx[vrsc_pkg::CB] ? 0 : scaled(rx[vrsc_pkg::CB-1:0], tw, sw);
			t = rt[vrsc_pkg::CB] ? 0 : scaled(rt[vrsc_pkg::CB-1:0], th, sh);
			w = scaled(rw, tw, sw);
			h = scaled(rh, th, sh);
			if (x < tw && t < th) begin
				if (x + w > tw) w = tw - x;
				if (t + h > th) h = th - t;
				if (w != 0 && h != 0) begin
					b = th - (t + h);
					r.x      = x[vrsc_pkg::CB-1:0];
					r.bottom = b[vrsc_pkg::CB-1:0];
					r.w      = w[vrsc_pkg::CB-1:0];
					r.h      = h[vrsc_pkg::CB-1:0];
				end
			end
		end
		pending.push_back(r);
	endfunction

	function void check_result(logic [vrsc_pkg::CB-1:0] ox, logic [vrsc_pkg::CB-1:0] ob,
		logic [vrsc_pkg::CB-1:0] ow, logic [vrsc_pkg::CB-1:0] oh);
		rect_res_t e;
		if (pending.size() == 0) begin
			$error("result with nothing pending: %0d %0d %0d %0d", ox, ob, ow, oh);
			errors++;
			return;
		end
		e = pending.pop_front();
		checked++;
		if (ox !== e.x) begin
			$error("out_x expected %0d got %0d", e.x, ox); errors++;
		end
		if (ob !== e.bottom) begin
			$error("out_bottom expected %0d got %0d", e.bottom, ob); errors++;
		end
		if (ow !== e.w) begin
			$error("out_width expected %0d got %0d", e.w, ow); errors++;
		end
		if (oh !== e.h) begin
			$error("out_height expected %0d got %0d", e.h, oh); errors++;
		end
	endfunction
endclass

module tb_viewport_rect_scale_clip_flip;
	localparam int CB     = vrsc_pkg::CB;
	localparam int ADDR_W = vrsc_pkg::ADDR_W;
	localparam int DATA_W = vrsc_pkg::DATA_W;

	localparam int LATENCY = 18;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	vrsc_rect_if rect ();
	vrsc_res_if res ();

	viewport_rect_scale_clip_flip uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.rect(rect.sink), .res(res.source)
	);

	rect_scoreboard board;
	longint cycles;
	int sent;
	int settings;
	bit idle_on;      // random idling enabled

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// result side: sample at rising edge, ready changes at falling edge
	initial begin
		int burst;
		res.ready = 1'b0;
		burst = 0;
		forever begin
			@(negedge clk);
			if (burst > 0) begin
				res.ready <= 1'b0;
				burst--;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				res.ready <= 1'b0;
				burst = $urandom_range(1, 12) - 1;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			board.check_result(res.out_x, res.out_bottom, res.out_width, res.out_height);
	end

	// one register write: setup then access cycle
	task automatic write_reg(vrsc_pkg::reg_idx_t idx, logic [CB-1:0] v);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(idx)); pwdata <= DATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		board.set_reg(idx, v);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic set_viewport(logic [CB-1:0] tw, logic [CB-1:0] th,
		logic [CB-1:0] sw, logic [CB-1:0] sh);
		write_reg(vrsc_pkg::REG_TW, tw);
		write_reg(vrsc_pkg::REG_TH, th);
		write_reg(vrsc_pkg::REG_SW, sw);
		write_reg(vrsc_pkg::REG_SH, sh);
		settings++;
	endtask

	// hand one rectangle over; valid stays high across back-to-back transactions
	task automatic send_rect(logic signed [CB:0] rx, logic signed [CB:0] rt,
		logic [CB-1:0] rw, logic [CB-1:0] rh);
		int gap;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			rect.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		rect.valid <= 1'b1;
		rect.rect_x <= rx; rect.rect_top <= rt;
		rect.rect_width <= rw; rect.rect_height <= rh;
		@(posedge clk);
		while (!rect.ready) @(posedge clk);
		board.note_rect(rx, rt, rw, rh);
		sent++;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		rect.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// random coordinate biased toward edges of the source window
	function automatic logic signed [CB:0] rand_origin(logic [CB-1:0] src);
		case ($urandom_range(0, 5))
			0: return $signed(15'($urandom));
			1: return -$signed(15'($urandom_range(1, 16384)));
			2: return 15'($urandom_range(0, 3));
			default: return 15'($urandom_range(0, int'(src) + 4));
		endcase
	endfunction

	function automatic logic [CB-1:0] rand_size(logic [CB-1:0] src);
		case ($urandom_range(0, 4))
			0: return 14'($urandom);
			1: return 14'($urandom_range(0, 2));
			default: return 14'($urandom_range(0, int'(src) + 4));
		endcase
	endfunction

	task automatic random_phase(int n);
		logic [CB-1:0] sw, sh;
		sw = board.sw; sh = board.sh;
		repeat (n)
			send_rect(rand_origin(sw), rand_origin(sh), rand_size(sw), rand_size(sh));
	endtask

	initial begin
		board = new();
		board.set_reg(vrsc_pkg::REG_TW, '0); board.set_reg(vrsc_pkg::REG_TH, '0);
		board.set_reg(vrsc_pkg::REG_SW, '0); board.set_reg(vrsc_pkg::REG_SH, '0);
		sent = 0; settings = 0;
		idle_on = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		rect.valid = 0; rect.rect_x = '0; rect.rect_top = '0;
		rect.rect_width = '0; rect.rect_height = '0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// registers still zero after reset: full empty target
		send_rect(15'sd10, 15'sd10, 14'd5, 14'd5);
		wait_drain();

		// directed: 2:1 scale both ways
		set_viewport(14'd800, 14'd600, 14'd400, 14'd300);
		send_rect(15'sd0, 15'sd0, 14'd400, 14'd300);          // whole window
		send_rect(15'sd10, 15'sd20, 14'd30, 14'd40);
		send_rect(-15'sd16384, -15'sd16384, 14'd100, 14'd100); // negative origin clamps
		send_rect(15'sd16383, 15'sd5, 14'd10, 14'd10);         // origin past right edge
		send_rect(15'sd5, 15'sd300, 14'd10, 14'd10);           // origin at bottom edge
		send_rect(15'sd399, 15'sd299, 14'd16383, 14'd16383);   // cut at the edge
		send_rect(15'sd1, 15'sd1, 14'd0, 14'd5);               // empty width
		send_rect(15'sd1, 15'sd1, 14'd5, 14'd0);               // empty height
		wait_drain();
		// 3:7 scale, rounding halves and empty by rounding
		set_viewport(14'd3, 14'd3, 14'd7, 14'd7);
		send_rect(15'sd0, 15'sd0, 14'd1, 14'd1);               // rounds to zero
		send_rect(15'sd1, 15'sd1, 14'd2, 14'd2);
		send_rect(15'sd3, 15'sd5, 14'd7, 14'd7);
		send_rect(-15'sd1, -15'sd1, 14'd16383, 14'd16383);
		wait_drain();
		// one size register zero
		set_viewport(14'd640, 14'd480, 14'd0, 14'd480);
		send_rect(15'sd10, 15'sd10, 14'd10, 14'd10);
		wait_drain();
		// extremes
		set_viewport(14'd16383, 14'd16383, 14'd1, 14'd1);
		send_rect(15'sd0, 15'sd0, 14'd1, 14'd1);
		send_rect(15'sd1, 15'sd0, 14'd16383, 14'd16383);
		wait_drain();
		set_viewport(14'd1, 14'd1, 14'd16383, 14'd16383);
		send_rect(15'sd0, 15'sd0, 14'd16383, 14'd16383);
		send_rect(15'sd8191, 15'sd8192, 14'd8192, 14'd8191);
		wait_drain();

		// random phases over several settings, idling on
		idle_on = 1'b1;
		set_viewport(14'd1920, 14'd1080, 14'd1280, 14'd720);
		random_phase(110);
		wait_drain();
		set_viewport(14'd16383, 14'd16383, 14'd16383, 14'd16383);
		random_phase(90);
		wait_drain();
		set_viewport(14'd100, 14'd16383, 14'd16383, 14'd3);
		random_phase(80);
		wait_drain();
		set_viewport(14'($urandom_range(1, 16383)), 14'($urandom_range(1, 16383)),
			14'($urandom_range(1, 16383)), 14'($urandom_range(1, 16383)));
		random_phase(90);
		wait_drain();
		set_viewport(14'($urandom_range(0, 2)), 14'($urandom_range(1, 300)),
			14'($urandom_range(1, 300)), 14'($urandom_range(0, 2)));
		random_phase(60);
		wait_drain();

		// last part at full rate, no idling
		idle_on = 1'b0;
		set_viewport(14'd1024, 14'd768, 14'd512, 14'd1536);
		random_phase(100);
		wait_drain();

		$display("covered %0d rectangles over %0d viewport settings, %0d results checked",
			sent, settings, board.checked);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

/* filelist.f */
+incdir+rtl
rtl/vrsc_pkg.sv
rtl/vrsc_if.sv
rtl/vrsc_div_cell.sv
rtl/vrsc_clip.sv
rtl/viewport_rect_scale_clip_flip.sv
rtl/vrsc_checker.sv
tb/tb_viewport_rect_scale_clip_flip.sv
